// ===== src/gf3_pkg.sv =====
// Shared types and constants for the 3x3 RGB Gaussian filter.
`timescale 1ns / 1ps
package gf3_pkg;

   localparam int DIM_W      = 11;
   localparam int ROW_W      = DIM_W + 1;
   localparam int WT_W       = 16;
   localparam int CH_W       = 8;
   localparam int PIX_W      = 3 * CH_W;
   localparam int COL_W      = 13;
   localparam int NTAPS      = 9;
   localparam int TAP_CENTER = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_W    = 2;
   localparam int SUM_W      = 12;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_EDGE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CORNER = 3'd4;

   typedef struct packed {
      logic [PIX_W-1:0] px;
      logic [COL_W-1:0] col;
      logic             has_out;
      logic             last;
      logic [NTAPS-1:0] mask;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic             push;
      logic [ROW_W-1:0] in_row;
      logic [DIM_W-1:0] out_row;
   } front_status_type;

endpackage

// ===== src/gf3_front.sv =====
// Front end: stream position counters, word classification, tap masks.
`timescale 1ns / 1ps
module gf3_front import gf3_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [DIM_W-1:0] cfg_width,
   input  logic [DIM_W-1:0] cfg_height,
   input  logic             cnt_clear,
   input  logic             in_valid,
   input  logic             in_action,
   input  logic [PIX_W-1:0] in_px,
   output logic             in_ready,
   output logic             push_valid,
   output q_entry_type      push_data,
   input  logic             push_ready,
   output front_status_type status
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int CMPW = ((CW > DIM_W) ? CW : DIM_W) + 1;

   logic [CW-1:0]    in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [DIM_W-1:0] out_row_ff, out_row_in;
   logic [DIM_W-1:0] eff_w, eff_h;
   logic             accepted, matched, pushes_done, primed;
   logic             col_wrap, ocol_end, orow_end, last;
   logic [2:0]       rowv, colv;

   assign eff_w = (cfg_width == '0) ? DIM_W'(1) :
                  (32'(cfg_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : cfg_width;
   assign eff_h = (cfg_height == '0) ? DIM_W'(1) : cfg_height;

   assign in_ready    = push_ready;
   assign accepted    = in_valid && push_ready;
   assign pushes_done = in_row_ff >= ROW_W'(eff_h);
   assign matched     = accepted && (in_action == pushes_done);
   assign primed      = (in_row_ff >= ROW_W'(2)) ||
                        ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));

   assign col_wrap = (CMPW'(in_col_ff) + CMPW'(1)) >= CMPW'(eff_w);
   assign ocol_end = (CMPW'(out_col_ff) + CMPW'(1)) >= CMPW'(eff_w);
   assign orow_end = (ROW_W'(out_row_ff) + ROW_W'(1)) >= ROW_W'(eff_h);
   assign last     = orow_end && ocol_end;

   assign rowv = {!orow_end, 1'b1, out_row_ff != '0};
   assign colv = {!ocol_end, 1'b1, out_col_ff != '0};

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            push_data.mask[j*3+k] = rowv[j] && colv[k];
         end
      end
      push_data.px      = in_action ? '0 : in_px;
      push_data.col     = COL_W'(in_col_ff);
      push_data.has_out = primed;
      push_data.last    = last;
   end

   assign push_valid = matched;

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (cnt_clear) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (matched) begin
         if (col_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
         if (primed) begin
            if (last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (ocol_end) begin
               out_col_in = '0;
               out_row_in = out_row_ff + DIM_W'(1);
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   assign status.push    = matched;
   assign status.in_row  = in_row_ff;
   assign status.out_row = out_row_ff;

endmodule

// ===== src/gf3_queue.sv =====
// Short FIFO between the front end and the filter datapath.
`timescale 1ns / 1ps
module gf3_queue import gf3_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  q_entry_type  push_data,
   output logic         push_ready,
   output logic         pop_valid,
   output q_entry_type  pop_data,
   input  logic         pop_ready,
   output q_status_type status
);

   q_entry_type        store_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_PTR_W:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = count_ff != (Q_PTR_W+1)'(Q_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = store_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + (Q_PTR_W+1)'(1);
      else if (!do_push && do_pop) count_in = count_ff - (Q_PTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + Q_PTR_W'(1);
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) store_ff[wr_ptr_ff] <= push_data;
   end

   assign status.full  = !push_ready;
   assign status.empty = !pop_valid;

endmodule

// ===== src/gf3_back.sv =====
// Filter datapath: line stores, 3x3 window, tap products, sum and output register.
`timescale 1ns / 1ps
module gf3_back import gf3_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [WT_W-1:0] wt_center,
   input  logic [WT_W-1:0] wt_edge,
   input  logic [WT_W-1:0] wt_corner,
   input  logic            pop_valid,
   input  q_entry_type     pop_data,
   output logic            pop_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [CH_W-1:0] rsp_red,
   output logic [CH_W-1:0] rsp_green,
   output logic [CH_W-1:0] rsp_blue,
   output logic            rsp_last
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic [2*PIX_W-1:0] mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rdata_ff, wdata;
   logic [CW-1:0]      raddr, a_col_ff;
   logic               en, take, we;

   logic             a_v_ff, a_has_ff, a_last_ff;
   logic [PIX_W-1:0] a_px_ff;
   logic [NTAPS-1:0] a_mask_ff;

   logic [PIX_W-1:0] win_ff [NTAPS];
   logic [PIX_W-1:0] win_in [NTAPS];
   logic             b_v_ff, b_has_ff, b_last_ff;
   logic [NTAPS-1:0] b_mask_ff;

   logic [CH_W-1:0]  prod_ff [3][NTAPS];
   logic [CH_W-1:0]  prod_in [3][NTAPS];
   logic             c_v_ff, c_has_ff, c_last_ff;

   logic [SUM_W-1:0] sum [3];
   logic [CH_W-1:0]  sat [3];

   logic             rsp_valid_ff;
   logic [CH_W-1:0]  red_ff, green_ff, blue_ff;
   logic             last_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign pop_ready = en;
   assign take      = en && pop_valid;
   assign raddr     = pop_data.col[CW-1:0];
   assign we        = en && a_v_ff;
   // store pair: upper half older row, lower half previous row
   assign wdata     = {rdata_ff[PIX_W-1:0], a_px_ff};

   always_ff @(posedge clock) begin
      if (we) mem[a_col_ff] <= wdata;
      if (take) begin
         if (we && (a_col_ff == raddr)) rdata_ff <= wdata;
         else rdata_ff <= mem[raddr];
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         win_in[j*3+0] = win_ff[j*3+1];
         win_in[j*3+1] = win_ff[j*3+2];
      end
      win_in[2] = rdata_ff[2*PIX_W-1:PIX_W];
      win_in[5] = rdata_ff[PIX_W-1:0];
      win_in[8] = a_px_ff;
   end

   always_comb begin
      logic [WT_W-1:0]      wt;
      logic [WT_W+CH_W-1:0] p;
      for (int t = 0; t < NTAPS; t++) begin
         if (t == TAP_CENTER) wt = wt_center;
         else if ((t % 2) == 1) wt = wt_edge;
         else wt = wt_corner;
         for (int ch = 0; ch < 3; ch++) begin
            p = wt * win_ff[t][(2-ch)*CH_W +: CH_W];
            prod_in[ch][t] = b_mask_ff[t] ? p[WT_W+CH_W-1:WT_W] : '0;
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum[ch] = '0;
         for (int t = 0; t < NTAPS; t++) begin
            sum[ch] = sum[ch] + SUM_W'(prod_ff[ch][t]);
         end
         sat[ch] = (sum[ch] > SUM_W'(255)) ? 8'hFF : sum[ch][CH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff       <= 1'b0;
         b_v_ff       <= 1'b0;
         c_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < NTAPS; t++) win_ff[t] <= '0;
      end else if (en) begin
         a_v_ff       <= pop_valid;
         b_v_ff       <= a_v_ff;
         c_v_ff       <= b_v_ff;
         rsp_valid_ff <= c_v_ff && c_has_ff;
         if (a_v_ff) begin
            for (int t = 0; t < NTAPS; t++) win_ff[t] <= win_in[t];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         a_px_ff   <= pop_data.px;
         a_col_ff  <= raddr;
         a_has_ff  <= pop_data.has_out;
         a_last_ff <= pop_data.last;
         a_mask_ff <= pop_data.mask;
      end
      if (en) begin
         b_has_ff  <= a_has_ff;
         b_last_ff <= a_last_ff;
         b_mask_ff <= a_mask_ff;
         c_has_ff  <= b_has_ff;
         c_last_ff <= b_last_ff;
         prod_ff   <= prod_in;
         red_ff    <= sat[0];
         green_ff  <= sat[1];
         blue_ff   <= sat[2];
         last_ff   <= c_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;
   assign rsp_last  = last_ff;

endmodule

// ===== src/gaussian_3x3_rgb_filter_core.sv =====
// Top level of the 3x3 RGB Gaussian filter: registers and block wiring.
//
// Pixels enter on req_ as one word each, raster order; req_tuser high marks
// a drain word, which pushes a blank pixel once the frame's pixels are in.
// A word that does not fit the frame state (pixel after the last one, drain
// before it) is taken and dropped. Filtered pixels leave on rsp_, the final
// one of a frame with rsp_tlast; the first result of a frame follows the
// word that completes one row and one pixel. After that one word in gives
// one word out, one per cycle when rsp_tready stays high. The pipeline
// steps behind the queue are line store read, window, tap products, and
// sum and saturation into the output register. A four-word queue behind
// the front counters keeps req_tready high while the receiver stalls
// until the queue fills; a stall freezes the datapath. csr_ writes
// (always ready) set the registers; writing width or height restarts
// the frame. Reset is synchronous: counters, window and registers
// return to defaults; line stores are not cleared.
`timescale 1ns / 1ps
module gaussian_3x3_rgb_filter_core import gf3_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // pixel_red, pixel_green, pixel_blue
   input  logic [0:0]            req_tuser,   // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // out_red, out_green, out_blue
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [DIM_W-1:0] width_ff, height_ff;
   logic [WT_W-1:0]  center_ff, edge_ff, corner_ff;
   logic             csr_wr, cnt_clear;

   q_entry_type      push_data, pop_data;
   logic             push_valid, push_ready, pop_valid, pop_ready;
   q_status_type     q_stat;
   front_status_type f_stat;
   logic [CH_W-1:0]  o_red, o_green, o_blue;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign cnt_clear = csr_wr && ((csr_index == REG_WIDTH) || (csr_index == REG_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(16);
         height_ff <= DIM_W'(9);
         center_ff <= WT_W'(40588);
         edge_ff   <= WT_W'(5493);
         corner_ff <= WT_W'(743);
      end else if (csr_wr) begin
         case (csr_index)
            REG_WIDTH:  width_ff  <= csr_data[DIM_W-1:0];
            REG_HEIGHT: height_ff <= csr_data[DIM_W-1:0];
            REG_CENTER: center_ff <= csr_data;
            REG_EDGE:   edge_ff   <= csr_data;
            REG_CORNER: corner_ff <= csr_data;
            default: ;
         endcase
      end
   end

   gf3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .cnt_clear  (cnt_clear),
      .in_valid   (req_tvalid),
      .in_action  (req_tuser[0]),
      .in_px      ({req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]}),
      .in_ready   (req_tready),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .status     (f_stat)
   );

   gf3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready),
      .status     (q_stat)
   );

   gf3_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .wt_center (center_ff),
      .wt_edge   (edge_ff),
      .wt_corner (corner_ff),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_red   (o_red),
      .rsp_green (o_green),
      .rsp_blue  (o_blue),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {o_blue, o_green, o_red};

   // a classified word always lands in the queue
   assert property (@(posedge clock) disable iff (reset)
      f_stat.push |=> !q_stat.empty)
      else $error("pushed word missing from queue");

   // front accepts only while the queue has room
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !q_stat.full)
      else $error("ready while queue full");

   // geometry write restarts the frame
   assert property (@(posedge clock) disable iff (reset)
      cnt_clear |=> (f_stat.in_row == '0) && (f_stat.out_row == '0))
      else $error("frame counters not cleared");

endmodule

// ===== verif/gf3_checker.sv =====
// Checker for the 3x3 RGB Gaussian filter: predicts each filtered word and compares it.
`timescale 1ns / 1ps
module gf3_checker import gf3_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [23:0]           req_tdata,   // pixel_red, pixel_green, pixel_blue
   input  logic [0:0]            req_tuser,   // action
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [23:0]           rsp_tdata,   // out_red, out_green, out_blue
   input  logic                  rsp_tlast,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending
);

   localparam int MAXW = 1024;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } blur_word_type;

   blur_word_type blur_q[$];

   logic [10:0] width_reg, height_reg;
   logic [15:0] wt_center, wt_edge, wt_corner;
   logic [23:0] line_a [MAXW];
   logic [23:0] line_b [MAXW];
   logic [23:0] win [9];           // packed red, green, blue from the top
   int unsigned in_col, in_row, out_col, out_row;

   initial begin
      fail_count = 0;
      for (int i = 0; i < MAXW; i++) begin
         line_a[i] = '0;
         line_b[i] = '0;
      end
   end

   assign pending = blur_q.size();

   function automatic int unsigned eff_w();
      if (width_reg < 1) return 1;
      if (width_reg > MAXW) return MAXW;
      return 32'(width_reg);
   endfunction

   function automatic int unsigned eff_h();
      return (height_reg < 1) ? 1 : 32'(height_reg);
   endfunction

   function automatic logic [7:0] blur_channel(int sh, int unsigned w, int unsigned h);
      int unsigned sum, wt, v;
      int r, c;
      sum = 0;
      for (int j = 0; j < 3; j++) begin
         r = int'(out_row) - 1 + j;
         if (r < 0 || r >= int'(h)) continue;
         for (int k = 0; k < 3; k++) begin
            c = int'(out_col) - 1 + k;
            if (c < 0 || c >= int'(w)) continue;
            if (j == 1 && k == 1) wt = 32'(wt_center);
            else if (j == 1 || k == 1) wt = 32'(wt_edge);
            else wt = 32'(wt_corner);
            v = (32'(win[j*3+k]) >> sh) & 32'hFF;
            sum += (wt * v) >> 16;
         end
      end
      return (sum > 255) ? 8'd255 : sum[7:0];
   endfunction

   task automatic clear_position();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
   endtask

   task automatic advance_stream(logic drain, logic [23:0] word);
      int unsigned w, h, col, pos;
      logic [23:0] px, old_a, old_b;
      blur_word_type e;
      w = eff_w();
      h = eff_h();
      if (drain != (in_row >= h)) return;
      // tdata has red in the low byte; keep red on top internally
      px = drain ? 24'd0 : {word[7:0], word[15:8], word[23:16]};
      col = (in_col < MAXW) ? in_col : 0;
      old_a = line_a[col];
      old_b = line_b[col];
      line_a[col] = old_b;
      line_b[col] = px;
      for (int j = 0; j < 3; j++) begin
         win[j*3]   = win[j*3+1];
         win[j*3+1] = win[j*3+2];
      end
      win[2] = old_a;
      win[5] = old_b;
      win[8] = px;
      pos = in_row * w + in_col;
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (pos < w + 1) return;
      e.red   = blur_channel(16, w, h);
      e.green = blur_channel(8, w, h);
      e.blue  = blur_channel(0, w, h);
      e.last  = (out_row + 1 >= h) && (out_col + 1 >= w);
      blur_q.push_back(e);
      if (e.last) clear_position();
      else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
   endtask

   always @(posedge clock) begin
      blur_word_type e;
      if (reset) begin
         width_reg  = 11'd16;
         height_reg = 11'd9;
         wt_center  = 16'd40588;
         wt_edge    = 16'd5493;
         wt_corner  = 16'd743;
         for (int i = 0; i < 9; i++) win[i] = '0;
         clear_position();
         blur_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (blur_q.size() == 0) begin
               $error("unexpected result word %h last %b", rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               e = blur_q.pop_front();
               if (rsp_tdata[7:0] !== e.red) begin
                  $error("out_red expected %0d actual %0d", e.red, rsp_tdata[7:0]);
                  fail_count++;
               end
               if (rsp_tdata[15:8] !== e.green) begin
                  $error("out_green expected %0d actual %0d", e.green, rsp_tdata[15:8]);
                  fail_count++;
               end
               if (rsp_tdata[23:16] !== e.blue) begin
                  $error("out_blue expected %0d actual %0d", e.blue, rsp_tdata[23:16]);
                  fail_count++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("frame_last expected %0d actual %0d", e.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) advance_stream(req_tuser[0], req_tdata);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_WIDTH: begin
                  width_reg = csr_data[10:0];
                  clear_position();
               end
               REG_HEIGHT: begin
                  height_reg = csr_data[10:0];
                  clear_position();
               end
               REG_CENTER: wt_center = csr_data;
               REG_EDGE:   wt_edge   = csr_data;
               REG_CORNER: wt_corner = csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the 3x3 RGB Gaussian filter: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_top;
   import gf3_pkg::*;

   localparam logic ACT_PUSH  = 1'b0;
   localparam logic ACT_DRAIN = 1'b1;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [23:0]           req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [23:0]           rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid = 0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int  fail_count, pending;
   int  words_sent = 0;
   int  cur_w = 16, cur_h = 9;
   bit  gaps_on = 1;
   bit  hold_rsp = 0;

   gaussian_3x3_rgb_filter_core u_dut (.*);

   gf3_checker u_chk (.*);

   initial forever #1 clock = ~clock;

   initial begin
      #2000000;
      $display("tb_top: FAIL");
      $finish;
   end

   // receiver flow control; the long hold waits for results so the block fills
   initial begin
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (hold_rsp && rsp_tvalid) begin
            rsp_tready <= 0;
            repeat (200) @(posedge clock);
            hold_rsp = 0;
         end
         rsp_tready <= 1;
         repeat ($urandom_range(0, 4) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 20))
            @(posedge clock);
         if ($urandom_range(0, 2) != 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
               @(posedge clock);
         end
      end
   end

   task automatic send_word(logic act, logic [23:0] data);
      req_tvalid <= 1;
      req_tuser  <= act;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
            @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
      if (idx == REG_WIDTH)
         cur_w = (val[10:0] < 1) ? 1 : (val[10:0] > 1024) ? 1024 : int'(val[10:0]);
      if (idx == REG_HEIGHT) cur_h = (val[10:0] < 1) ? 1 : int'(val[10:0]);
   endtask

   function automatic logic [23:0] rand_pixel();
      case ($urandom_range(0, 5))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         2: return $urandom_range(0, 1) ? 24'hAAAAAA : 24'h555555;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_weight(int unsigned nominal);
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'(nominal + $urandom_range(0, 2000) - 1000);
      endcase
   endfunction

   // one frame; noise inserts ignored words; a cut frame stops early
   task automatic run_frame(int noise, bit cut);
      int stop;
      stop = cut ? $urandom_range(0, cur_w * cur_h) : cur_w * cur_h;
      for (int i = 0; i < stop; i++) begin
         if ($urandom_range(0, 99) < noise) send_word(ACT_DRAIN, 24'($urandom));
         send_word(ACT_PUSH, rand_pixel());
      end
      if (cut) return;
      if ($urandom_range(0, 99) < noise * 4) send_word(ACT_PUSH, rand_pixel());
      for (int i = 0; i < cur_w + 1; i++) send_word(ACT_DRAIN, 24'($urandom));
   endtask

   initial begin
      int n;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: saturation, zero weights, degenerate sizes, ignored words
      write_reg(REG_WIDTH, 3);
      write_reg(REG_HEIGHT, 2);
      write_reg(REG_CENTER, 16'hFFFF);
      write_reg(REG_EDGE, 16'hFFFF);
      write_reg(REG_CORNER, 16'hFFFF);
      send_word(ACT_DRAIN, 24'hFFFFFF);
      send_word(ACT_PUSH, 24'hFFFFFF);
      send_word(ACT_PUSH, 24'h000000);
      send_word(ACT_PUSH, 24'hAAAAAA);
      send_word(ACT_PUSH, 24'h555555);
      send_word(ACT_PUSH, 24'hFFFFFF);
      send_word(ACT_PUSH, 24'h010101);
      send_word(ACT_PUSH, 24'hFFFFFF);
      for (int i = 0; i < 4; i++) send_word(ACT_DRAIN, 24'h000000);
      wait_idle();
      write_reg(REG_WIDTH, 0);
      write_reg(REG_HEIGHT, 0);
      send_word(ACT_PUSH, 24'hFF00FF);
      send_word(ACT_DRAIN, '0);
      send_word(ACT_DRAIN, '0);
      wait_idle();
      write_reg(REG_WIDTH, 2);
      write_reg(REG_HEIGHT, 1);
      write_reg(REG_CENTER, 0);
      write_reg(REG_EDGE, 0);
      write_reg(REG_CORNER, 0);
      send_word(ACT_PUSH, 24'hFFFFFF);
      send_word(ACT_PUSH, 24'h808080);
      for (int i = 0; i < 3; i++) send_word(ACT_DRAIN, '0);
      wait_idle();

      // reset-like defaults, then a long receiver hold and a tall narrow frame
      write_reg(REG_WIDTH, 16);
      write_reg(REG_HEIGHT, 9);
      write_reg(REG_CENTER, 40588);
      write_reg(REG_EDGE, 5493);
      write_reg(REG_CORNER, 743);
      run_frame(2, 0);
      wait_idle();
      write_reg(REG_WIDTH, 40);
      write_reg(REG_HEIGHT, 12);
      gaps_on = 0;
      hold_rsp = 1;
      run_frame(0, 0);
      gaps_on = 1;
      wait_idle();
      write_reg(REG_WIDTH, 1);
      write_reg(REG_HEIGHT, 300);
      run_frame(1, 0);
      wait_idle();

      // random frames
      n = words_sent;
      while (words_sent - n < 650) begin
         if ($urandom_range(0, 1)) write_reg(REG_CENTER, rand_weight(40588));
         if ($urandom_range(0, 1)) write_reg(REG_EDGE, rand_weight(5493));
         if ($urandom_range(0, 1)) write_reg(REG_CORNER, rand_weight(743));
         write_reg(REG_WIDTH, 16'($urandom_range(0, 7) == 0 ? $urandom_range(13, 40)
                                                            : $urandom_range(1, 12)));
         write_reg(REG_HEIGHT, 16'($urandom_range(1, 6)));
         gaps_on = $urandom_range(0, 3) != 0;
         run_frame($urandom_range(0, 3), $urandom_range(0, 9) == 0);
         wait_idle();
      end

      n = 0;
      while (pending != 0 && n < 100000) begin
         @(posedge clock);
         n++;
      end
      if (n >= 100000) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         repeat (20) @(posedge clock);
         if (fail_count == 0 && pending == 0) begin
            $display("tb_top: PASS");
         end else begin
            $display("tb_top: FAIL");
         end
         $finish;
      end
   end

endmodule

// ===== files.f =====
src/gf3_pkg.sv
src/gf3_front.sv
src/gf3_queue.sv
src/gf3_back.sv
src/gaussian_3x3_rgb_filter_core.sv
verif/gf3_checker.sv
verif/tb_top.sv
